@@ sv/ssk_pkg.sv @@
// shared types, widths and codes for the stable sorted key index
// depends on nothing; every other file imports it
package ssk_pkg;

  localparam int KEY_W       = 64;
  localparam int TAG_W       = 32;
  localparam int RANK_W      = 8;
  localparam int OUT_CNT_W   = 9;
  localparam int DEF_ENTRIES = 256;

  typedef logic [KEY_W-1:0]     key_t;
  typedef logic [TAG_W-1:0]     tag_t;
  typedef logic [RANK_W-1:0]    rank_t;
  typedef logic [OUT_CNT_W-1:0] ocnt_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_FIND   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_ZERO  = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_WALK = 2'd2,
    S_DONE = 2'd3
  } state_t;

  // command broadcast from the controller to every cell
  typedef struct packed {
    logic  shift_en;  // insert: open a slot and write the new pair
    logic  launch;    // read/find: load the result lane
    logic  strict;    // 1: compare key > k (insert), 0: key >= k (find)
    logic  is_find;
    key_t  key;
    tag_t  tag;
    rank_t rank;
  } cmd_t;

  // one slot of the result lane that runs toward cell 0
  typedef struct packed {
    logic vld;
    key_t key;
    tag_t tag;
    logic match;
  } lane_t;

  // assembled result transaction
  typedef struct packed {
    status_t status;
    key_t    key;
    tag_t    tag;
    ocnt_t   found;
    logic    match;
  } res_t;

endpackage

@@ sv/ssk_cell.sv @@
// one cell of the sorted chain: holds one (key, tag) pair and one result lane slot
// depends on ssk_pkg
module ssk_cell #(
  parameter int ENTRIES = ssk_pkg::DEF_ENTRIES,
  parameter int IDX     = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ssk_pkg::cmd_t                  cmd,
  input  logic [$clog2(ENTRIES+1)-1:0]   count,
  input  logic                           flag_in,
  output logic                           flag_out,
  input  ssk_pkg::key_t                  left_key,
  input  ssk_pkg::tag_t                  left_tag,
  output ssk_pkg::key_t                  ent_key,
  output ssk_pkg::tag_t                  ent_tag,
  input  ssk_pkg::lane_t                 lane_in,
  output ssk_pkg::lane_t                 lane_out
);
  import ssk_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int RW = (CW > RANK_W) ? CW : RANK_W;

  key_t  key_r;
  tag_t  tag_r;
  lane_t lane_r;
  lane_t lane_next;
  logic  held;
  logic  lt;
  logic  eq;
  logic  hit;

  // slot holds a pair when its position is below the fill count
  assign held = (CW'(IDX) < count);
  assign lt   = (key_r < cmd.key);
  assign eq   = (key_r == cmd.key);

  // boundary flag: empty slot, or key above (insert) / at or above (find)
  assign flag_out = !held || !(lt || (cmd.strict && eq));

  // stored pair: shift from the left neighbor or take the new pair at the boundary
  always_ff @(posedge clk) begin
    if (cmd.shift_en && flag_out) begin
      if (flag_in) begin
        key_r <= left_key;
        tag_r <= left_tag;
      end else begin
        key_r <= cmd.key;
        tag_r <= cmd.tag;
      end
    end
  end

  assign ent_key = key_r;
  assign ent_tag = tag_r;

  // this cell is the answer: first boundary for find, the addressed slot for read
  always_comb begin
    if (cmd.is_find) begin
      hit = flag_out && !flag_in;
    end else begin
      hit = held && (RW'(IDX) == RW'(cmd.rank));
    end
  end

  // result lane: load on launch, otherwise pass the right neighbor's slot along
  always_comb begin
    if (cmd.launch) begin
      lane_next.vld = hit;
      if (held) begin
        lane_next.key   = key_r;
        lane_next.tag   = tag_r;
        lane_next.match = cmd.is_find && eq;
      end else begin
        lane_next.key   = '0;
        lane_next.tag   = '0;
        lane_next.match = 1'b0;
      end
    end else begin
      lane_next = lane_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_r.vld <= 1'b0;
    end else begin
      lane_r <= lane_next;
    end
  end

  assign lane_out = lane_r;

endmodule

@@ sv/ssk_chain.sv @@
// row of ssk_cell instances plus the virtual slot past the last cell
// depends on ssk_pkg and ssk_cell
module ssk_chain #(
  parameter int ENTRIES = ssk_pkg::DEF_ENTRIES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ssk_pkg::cmd_t                  cmd,
  input  logic [$clog2(ENTRIES+1)-1:0]   count,
  output ssk_pkg::lane_t                 lane_head
);
  import ssk_pkg::*;

  logic  flag [ENTRIES:0];
  key_t  ekey [ENTRIES-1:0];
  tag_t  etag [ENTRIES-1:0];
  lane_t lane [ENTRIES:0];
  lane_t tail_r;

  assign flag[0] = 1'b0;

  genvar i;
  generate
    for (i = 0; i < ENTRIES; i++) begin : g_cell
      key_t lk;
      tag_t lt;
      if (i == 0) begin : g_first
        assign lk = '0;
        assign lt = '0;
      end else begin : g_rest
        assign lk = ekey[i-1];
        assign lt = etag[i-1];
      end
      ssk_cell #(
        .ENTRIES(ENTRIES),
        .IDX    (i)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .cmd     (cmd),
        .count   (count),
        .flag_in (flag[i]),
        .flag_out(flag[i+1]),
        .left_key(lk),
        .left_tag(lt),
        .ent_key (ekey[i]),
        .ent_tag (etag[i]),
        .lane_in (lane[i+1]),
        .lane_out(lane[i])
      );
    end
  endgenerate

  // virtual slot at rank ENTRIES: find of a key above a full table
  always_ff @(posedge clk) begin
    if (rst) begin
      tail_r.vld <= 1'b0;
    end else begin
      tail_r.vld   <= cmd.launch && cmd.is_find && !flag[ENTRIES];
      tail_r.key   <= '0;
      tail_r.tag   <= '0;
      tail_r.match <= 1'b0;
    end
  end

  assign lane[ENTRIES] = tail_r;
  assign lane_head     = lane[0];

endmodule

@@ sv/stable_sorted_key_index.sv @@
// Stable sorted key index. Holds up to ENTRIES (key, tag) pairs in ascending key order in
// a row of cells; equal keys keep insertion order. One transaction at a time is worked on,
// and a new one is taken while the previous result waits on the output. Insert, clear and a
// read past the held pairs go from the execute state straight to the done state. Read at
// rank r and find walk the result lane: every cell compares in parallel, but the selected
// pair travels one cell per cycle down the result lane toward cell 0, so they take longer
// the higher the rank. A finished result waits in place, and input is held off, while an
// earlier result is still stalled on the output. No clearing pass is needed after reset.
// Depends on ssk_pkg and ssk_chain.
module stable_sorted_key_index #(
  parameter int ENTRIES = ssk_pkg::DEF_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      op,
  input  logic [ssk_pkg::KEY_W-1:0]       key,
  input  logic [ssk_pkg::TAG_W-1:0]       tag,
  input  logic [ssk_pkg::RANK_W-1:0]      rank,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      status,
  output logic [ssk_pkg::KEY_W-1:0]       key_out,
  output logic [ssk_pkg::TAG_W-1:0]       tag_out,
  output logic [ssk_pkg::OUT_CNT_W-1:0]   found_rank,
  output logic                            match,
  output logic [ssk_pkg::OUT_CNT_W-1:0]   entry_count
);
  import ssk_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int RW = (CW > RANK_W) ? CW : RANK_W;

  state_t        state;
  state_t        state_next;
  op_t           op_q;
  key_t          key_q;
  tag_t          tag_q;
  rank_t         rank_q;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] walk_cnt;
  logic [CW-1:0] walk_cnt_next;
  res_t          res;
  res_t          res_next;
  cmd_t          cmd;
  lane_t         lane_head;
  logic          load_out;
  logic          full;
  logic          in_range;

  assign in_ready = (state == S_IDLE);
  assign full     = (count >= CW'(ENTRIES));
  assign in_range = (RW'(rank_q) < RW'(count));

  ssk_chain #(
    .ENTRIES(ENTRIES)
  ) u_chain (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .count    (count),
    .lane_head(lane_head)
  );

  // state register and control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      walk_cnt <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      walk_cnt <= walk_cnt_next;
    end
  end

  // captured transaction and pending result
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q   <= op_t'(op);
      key_q  <= key;
      tag_q  <= tag;
      rank_q <= rank;
    end
    res <= res_next;
  end

  // next state, cell command and result assembly
  always_comb begin
    state_next    = state;
    count_next    = count;
    walk_cnt_next = walk_cnt;
    res_next      = res;
    load_out      = 1'b0;
    cmd.shift_en  = 1'b0;
    cmd.launch    = 1'b0;
    cmd.strict    = (op_q == OP_INSERT);
    cmd.is_find   = (op_q == OP_FIND);
    cmd.key       = key_q;
    cmd.tag       = tag_q;
    cmd.rank      = rank_q;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        res_next        = '0;
        res_next.status = STAT_OK;
        walk_cnt_next   = '0;
        case (op_q)
          OP_INSERT: begin
            state_next = S_DONE;
            if (key_q == '0) begin
              res_next.status = STAT_ZERO;
            end else if (full) begin
              res_next.status = STAT_FULL;
            end else begin
              cmd.shift_en = 1'b1;
              count_next   = count + CW'(1);
            end
          end
          OP_READ: begin
            if (in_range) begin
              cmd.launch = 1'b1;
              state_next = S_WALK;
            end else begin
              res_next.status = STAT_RANGE;
              state_next      = S_DONE;
            end
          end
          OP_FIND: begin
            cmd.launch = 1'b1;
            state_next = S_WALK;
          end
          OP_CLEAR: begin
            count_next = '0;
            state_next = S_DONE;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_WALK: begin
        if (lane_head.vld) begin
          res_next.key   = lane_head.key;
          res_next.tag   = lane_head.tag;
          res_next.match = lane_head.match;
          res_next.found = (op_q == OP_FIND) ? OUT_CNT_W'(walk_cnt) : '0;
          state_next     = S_DONE;
        end else begin
          walk_cnt_next = walk_cnt + CW'(1);
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status      <= res.status;
      key_out     <= res.key;
      tag_out     <= res.tag;
      found_rank  <= res.found;
      match       <= res.match;
      entry_count <= OUT_CNT_W'(count);
    end
  end

endmodule

@@ sv/ssk_checker.sv @@
// port-level checks for stable_sorted_key_index, attached by bind
// depends on ssk_pkg
module ssk_checker #(
  parameter int ENTRIES = ssk_pkg::DEF_ENTRIES
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [1:0]                      op,
  input logic [ssk_pkg::KEY_W-1:0]       key,
  input logic [ssk_pkg::TAG_W-1:0]       tag,
  input logic [ssk_pkg::RANK_W-1:0]      rank,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [1:0]                      status,
  input logic [ssk_pkg::KEY_W-1:0]       key_out,
  input logic [ssk_pkg::TAG_W-1:0]       tag_out,
  input logic [ssk_pkg::OUT_CNT_W-1:0]   found_rank,
  input logic                            match,
  input logic [ssk_pkg::OUT_CNT_W-1:0]   entry_count
);
  import ssk_pkg::*;

  // a waiting input transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(op) && $stable(key) && $stable(tag)
      && $stable(rank))
    else $error("input changed while waiting");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(key_out) && $stable(tag_out)
      && $stable(status) && $stable(found_rank) && $stable(entry_count))
    else $error("result changed while stalled");

  // fill count never exceeds the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ENTRIES >= 512) || (entry_count <= OUT_CNT_W'(ENTRIES)))
    else $error("entry count above table size");

  // out-of-range read carries no pair
  a_range_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_RANGE |-> key_out == '0 && tag_out == '0
      && found_rank == '0 && !match)
    else $error("out-of-range read returned data");

  // a match is a successful lookup of a stored, nonzero key
  a_match_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && match |-> status == STAT_OK && key_out != '0)
    else $error("match on a failed or empty lookup");

endmodule

bind stable_sorted_key_index ssk_checker #(.ENTRIES(ENTRIES)) u_ssk_checker (.*);
